/* hw/rtl/tts_pkg.sv */
package tts_pkg;

	localparam int MAX_SLOTS      = 8;
	localparam int TASK_SLOTS_DEF = 8;
	localparam int MASK_W         = 8;
	localparam int IDX_W          = 3;
	localparam int TIME_W         = 32;
	localparam int TICK_W         = 16;
	localparam int COUNT_W        = 16;

	localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 16'd1000;

	typedef enum logic [1:0] {
		REQ_TICK        = 2'd0,
		REQ_SCHED       = 2'd1,
		REQ_SET_PERIOD  = 2'd2,
		REQ_READ_PERIOD = 2'd3
	} req_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT
	} state_e;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [IDX_W-1:0]   task_index;
		logic [TIME_W-1:0]  initial_delay_us;
		logic [TIME_W-1:0]  task_period;
		logic [COUNT_W-1:0] repetitions;
	} sched_req_t;

	typedef struct packed {
		logic [MASK_W-1:0] fire_mask;
		logic [TIME_W-1:0] read_period;
		logic              status;
	} sched_rsp_t;

	typedef struct packed {
		logic load_req;
		logic walk_step;
		logic emit;
	} tts_cmd_t;

	typedef struct packed {
		logic in_tick;
		logic walk_last;
		logic out_free;
	} tts_stat_t;

endpackage

/* hw/rtl/tts_ctrl.sv */
module tts_ctrl
	import tts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  tts_stat_t stat,
	output tts_cmd_t  cmd
);

	state_e state_q;
	state_e state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = stat.in_tick ? ST_WALK : ST_EMIT;
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/tts_datapath.sv */
module tts_datapath
	import tts_pkg::*;
#(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sched_req_t        req,
	input  logic              cfg_valid,
	input  logic [TICK_W-1:0] cfg_data,
	input  tts_cmd_t          cmd,
	output tts_stat_t         stat,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sched_rsp_t        rsp
);

	// slots past the index range can never be scheduled
	localparam int USED_SLOTS = (TASK_SLOTS < MAX_SLOTS) ? TASK_SLOTS : MAX_SLOTS;
	localparam int SLOT_W     = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;

	logic [TICK_W-1:0]  tick_q;
	sched_req_t         req_q;
	logic [SLOT_W-1:0]  walk_idx_q;
	logic [MASK_W-1:0]  mask_q;
	sched_rsp_t         rsp_q;
	logic               rsp_valid_q;

	logic               act_q [USED_SLOTS];
	logic [TIME_W-1:0]  per_q [USED_SLOTS];
	logic [TIME_W-1:0]  cnt_q [USED_SLOTS];
	logic [COUNT_W-1:0] lim_q [USED_SLOTS];
	logic [COUNT_W-1:0] run_q [USED_SLOTS];

	logic [TIME_W-1:0]  tp;
	logic               idx_ok;
	logic [SLOT_W-1:0]  req_idx;
	logic [SLOT_W-1:0]  rd_idx;
	logic               act_rd;
	logic [TIME_W-1:0]  per_rd;
	logic [TIME_W-1:0]  cnt_rd;
	logic [COUNT_W-1:0] lim_rd;
	logic [COUNT_W-1:0] run_rd;
	logic               due;
	logic               fire;
	logic [COUNT_W-1:0] run_nx;
	logic               reject;
	logic               sched_wr;
	logic               period_wr;
	sched_rsp_t         rsp_d;

	assign tp      = {{(TIME_W-TICK_W){1'b0}}, tick_q};
	assign idx_ok  = {1'b0, req_q.task_index} < (IDX_W+1)'(USED_SLOTS);
	assign req_idx = idx_ok ? req_q.task_index[SLOT_W-1:0] : '0;
	assign rd_idx  = cmd.walk_step ? walk_idx_q : req_idx;

	assign act_rd = act_q[rd_idx];
	assign per_rd = per_q[rd_idx];
	assign cnt_rd = cnt_q[rd_idx];
	assign lim_rd = lim_q[rd_idx];
	assign run_rd = run_q[rd_idx];

	// slot evaluation during the walk
	assign due    = cnt_rd <= tp;
	assign fire   = act_rd && due && ((run_rd < lim_rd) || (lim_rd == '0));
	assign run_nx = (run_rd == '1) ? COUNT_W'(1) : run_rd + COUNT_W'(1);

	assign reject    = (req_q.initial_delay_us < tp) || (req_q.task_period < tp);
	assign sched_wr  = cmd.emit && idx_ok && (req_q.req_type == REQ_SCHED) && !reject;
	assign period_wr = cmd.emit && idx_ok && (req_q.req_type == REQ_SET_PERIOD);

	assign stat.in_tick   = req.req_type == REQ_TICK;
	assign stat.walk_last = walk_idx_q == SLOT_W'(USED_SLOTS - 1);
	assign stat.out_free  = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= TICK_PERIOD_RST;
		end else if (cfg_valid) begin
			tick_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_idx_q <= '0;
			mask_q     <= '0;
		end else if (cmd.load_req) begin
			walk_idx_q <= '0;
			mask_q     <= '0;
		end else if (cmd.walk_step) begin
			walk_idx_q <= walk_idx_q + SLOT_W'(1);
			if (fire) begin
				mask_q <= mask_q | (MASK_W'(1) << walk_idx_q);
			end
		end
	end

	// slot table, control and period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < USED_SLOTS; i++) begin
				act_q[i] <= 1'b0;
				per_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < USED_SLOTS; i++) begin
				if ((sched_wr || period_wr) && req_idx == SLOT_W'(i)) begin
					per_q[i] <= req_q.task_period;
				end
				if (sched_wr && req_idx == SLOT_W'(i)) begin
					act_q[i] <= 1'b1;
				end
			end
		end
	end

	// slot table, countdown and counters
	always_ff @(posedge clk) begin
		for (int i = 0; i < USED_SLOTS; i++) begin
			if (cmd.walk_step && walk_idx_q == SLOT_W'(i)) begin
				if (fire) begin
					run_q[i] <= run_nx;
					cnt_q[i] <= per_rd;
				end else if (act_rd && !due) begin
					cnt_q[i] <= cnt_rd - tp;
				end
			end else if (sched_wr && req_idx == SLOT_W'(i)) begin
				cnt_q[i] <= req_q.initial_delay_us;
				lim_q[i] <= req_q.repetitions;
				run_q[i] <= '0;
			end
		end
	end

	always_comb begin
		rsp_d = '0;
		unique case (req_q.req_type)
			REQ_TICK:        rsp_d.fire_mask   = mask_q;
			REQ_SCHED:       rsp_d.status      = reject;
			REQ_SET_PERIOD:  rsp_d             = '0;
			REQ_READ_PERIOD: rsp_d.read_period = idx_ok ? per_rd : '0;
			default:         rsp_d             = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwritten while held");

	a_walk_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> !cmd.emit && !cmd.load_req)
		else $error("walk overlaps another command");

	a_reject_status: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && req_q.req_type == REQ_SCHED && reject |=> rsp_valid && rsp.status)
		else $error("rejected schedule without status");

	a_status_mask: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.fire_mask == '0 && rsp.read_period == '0)
		else $error("reject word carries data");
`endif

endmodule

/* hw/rtl/periodic_task_tick_scheduler.sv */
// channel | dir | handshake             | word
// req     | in  | req_valid / req_ready | sched_req_t
// rsp     | out | rsp_valid / rsp_ready | sched_rsp_t
// cfg     | in  | cfg_valid / cfg_ready | tick period, 16 bit
//
// a tick walks the USED_SLOTS slots one slot per cycle (ST_WALK) before ST_EMIT
// (USED_SLOTS is TASK_SLOTS capped at 8); other requests go from ST_IDLE to ST_EMIT
// one word is in work at a time; the next word is taken once the result is registered
// a held result stalls only the ST_EMIT state of the following word
// arst_n clears the active flags and the period registers and sets the tick period to 1000
module periodic_task_tick_scheduler
	import tts_pkg::*;
#(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  sched_req_t        req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sched_rsp_t        rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TICK_W-1:0] cfg_data
);

	tts_cmd_t  cmd;
	tts_stat_t stat;

	assign cfg_ready = 1'b1;

	tts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tts_datapath #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

/* tb/periodic_task_tick_scheduler_tb.sv */
module periodic_task_tick_scheduler_tb;
	import tts_pkg::*;

	localparam int SLOTS       = TASK_SLOTS_DEF;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE      = 12;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	sched_req_t req_word;
	logic       rsp_valid;
	logic       rsp_ready;
	sched_rsp_t rsp_word;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [TICK_W-1:0] cfg_data;

	periodic_task_tick_scheduler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the slot table
	logic [TICK_W-1:0]  tick_us;
	logic               slot_on   [SLOTS];
	logic [TIME_W-1:0]  slot_cd   [SLOTS];
	logic [TIME_W-1:0]  slot_per  [SLOTS];
	logic [COUNT_W-1:0] slot_lim  [SLOTS];
	logic [COUNT_W-1:0] slot_runs [SLOTS];

	sched_rsp_t pending_rsp[$];

	int  errors;
	int  words_sent;
	int  words_checked;
	int  fires_seen;
	int  rejects_seen;
	int  quiet_cycles;
	bit  calm;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_wait();
		if (calm)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	function automatic sched_rsp_t apply_request(sched_req_t r);
		sched_rsp_t  o;
		logic [31:0] tp;
		logic [2:0]  i;
		o  = '0;
		tp = {16'd0, tick_us};
		i  = r.task_index;
		case (req_e'(r.req_type))
			REQ_TICK: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (slot_on[s]) begin
						if (slot_cd[s] <= tp) begin
							if (slot_runs[s] < slot_lim[s] || slot_lim[s] == 0) begin
								slot_runs[s] = slot_runs[s] + 16'd1;
								if (slot_runs[s] == 0)
									slot_runs[s] = 16'd1;
								slot_cd[s] = slot_per[s];
								o.fire_mask[s] = 1'b1;
							end
						end else begin
							slot_cd[s] = slot_cd[s] - tp;
						end
					end
				end
			end
			REQ_SCHED: begin
				if (r.initial_delay_us < tp || r.task_period < tp) begin
					o.status = 1'b1;
				end else begin
					slot_cd[i]   = r.initial_delay_us;
					slot_per[i]  = r.task_period;
					slot_lim[i]  = r.repetitions;
					slot_runs[i] = '0;
					slot_on[i]   = 1'b1;
				end
			end
			REQ_SET_PERIOD: begin
				slot_per[i] = r.task_period;
			end
			default: begin
				o.read_period = slot_per[i];
			end
		endcase
		return o;
	endfunction

	function automatic sched_req_t mk(req_e t, int idx, logic [31:0] d, logic [31:0] p,
			logic [15:0] n);
		sched_req_t r;
		r.req_type         = t;
		r.task_index       = idx[2:0];
		r.initial_delay_us = d;
		r.task_period      = p;
		r.repetitions      = n;
		return r;
	endfunction

	function automatic logic [31:0] pick_time();
		int unsigned     sel;
		longint unsigned v;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return $urandom;
		if (sel == 1)
			return 32'hFFFF_FFFF;
		if (sel == 2)
			return (tick_us == 0) ? 32'd0 : {16'd0, tick_us} - 32'd1;
		v = longint'(tick_us) * $urandom_range(1, 4) + $urandom_range(0, tick_us);
		return v[31:0];
	endfunction

	function automatic sched_req_t rand_req();
		sched_req_t  r;
		int unsigned k;
		k = $urandom_range(0, 99);
		r = mk(REQ_TICK, $urandom_range(0, 7), $urandom, $urandom, 16'($urandom));
		if (k < 45) begin
			r.req_type = REQ_TICK;
		end else if (k < 70) begin
			r.req_type         = REQ_SCHED;
			r.initial_delay_us = pick_time();
			r.task_period      = pick_time();
			if ($urandom_range(0, 9) != 0)
				r.repetitions = 16'($urandom_range(0, 4));
		end else if (k < 82) begin
			r.req_type = REQ_SET_PERIOD;
			if ($urandom_range(0, 3) != 0)
				r.task_period = pick_time();
		end else begin
			r.req_type = REQ_READ_PERIOD;
		end
		return r;
	endfunction

	task automatic send_word(input sched_req_t w);
		int gap;
		gap = pick_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_word  <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_rsp.push_back(apply_request(w));
		words_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic set_tick(input logic [15:0] v);
		drain();
		repeat (SETTLE) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tick_us = v;
	endtask

	task automatic check_rsp(input sched_rsp_t got);
		sched_rsp_t want;
		if (pending_rsp.size() == 0) begin
			errors++;
			$display("%0t unexpected word: mask %h period %h status %b", $time,
				got.fire_mask, got.read_period, got.status);
			return;
		end
		want = pending_rsp.pop_front();
		words_checked++;
		fires_seen   += $countones(got.fire_mask);
		rejects_seen += got.status;
		if (got.fire_mask !== want.fire_mask) begin
			errors++;
			$display("%0t fire_mask: expected %h, got %h", $time, want.fire_mask,
				got.fire_mask);
		end
		if (got.read_period !== want.read_period) begin
			errors++;
			$display("%0t read_period: expected %h, got %h", $time, want.read_period,
				got.read_period);
		end
		if (got.status !== want.status) begin
			errors++;
			$display("%0t status: expected %b, got %b", $time, want.status, got.status);
		end
	endtask

	initial begin
		int stall;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_wait();
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			check_rsp(rsp_word);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t no word moved for %0d cycles", $time, quiet_cycles);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	task automatic test_power_on();
		calm = 1'b0;
		for (int s = 0; s < SLOTS; s++)
			send_word(mk(REQ_READ_PERIOD, s, $urandom, $urandom, 16'($urandom)));
		send_word(mk(REQ_TICK, 0, 0, 0, 0));
	endtask

	task automatic test_directed();
		send_word(mk(REQ_SCHED, 0, 32'd999, 32'd5000, 16'd1));
		send_word(mk(REQ_SCHED, 1, 32'd1000, 32'd999, 16'd1));
		send_word(mk(REQ_SCHED, 2, 32'd0, 32'd0, 16'd0));
		send_word(mk(REQ_SCHED, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
		send_word(mk(REQ_SCHED, 0, 32'd1000, 32'd1000, 16'd2));
		send_word(mk(REQ_SET_PERIOD, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
		send_word(mk(REQ_READ_PERIOD, 3, 0, 0, 0));
		// slot 0 fires twice, then stays exhausted
		repeat (3) send_word(mk(REQ_TICK, 7, $urandom, $urandom, 16'($urandom)));
		send_word(mk(REQ_SCHED, 1, 32'd2500, 32'd1500, 16'd0));
		repeat (4) send_word(mk(REQ_TICK, 0, 0, 0, 0));
		send_word(mk(REQ_SET_PERIOD, 1, 32'd0, 32'd0, 16'd0));
		repeat (3) send_word(mk(REQ_TICK, 0, 0, 0, 0));
		send_word(mk(REQ_READ_PERIOD, 7, 0, 0, 0));
		send_word(mk(REQ_READ_PERIOD, 1, 0, 0, 0));
		send_word(mk(REQ_TICK, 3, 0, 0, 0));
	endtask

	task automatic test_zero_tick();
		set_tick(16'd0);
		calm = 1'b1;
		send_word(mk(REQ_SCHED, 2, 32'd0, 32'd0, 16'd3));
		send_word(mk(REQ_SCHED, 5, 32'd1, 32'd0, 16'd0));
		repeat (5) send_word(mk(REQ_TICK, 0, 0, 0, 0));
		calm = 1'b0;
	endtask

	task automatic test_random(input logic [15:0] tick, input int count);
		set_tick(tick);
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			send_word(rand_req());
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_word  = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		errors        = 0;
		words_sent    = 0;
		words_checked = 0;
		fires_seen    = 0;
		rejects_seen  = 0;
		quiet_cycles  = 0;
		calm          = 1'b0;
		tick_us = TICK_PERIOD_RST;
		for (int s = 0; s < SLOTS; s++) begin
			slot_on[s]   = 1'b0;
			slot_cd[s]   = '0;
			slot_per[s]  = '0;
			slot_lim[s]  = '0;
			slot_runs[s] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on();
		test_directed();
		test_zero_tick();
		test_random(16'd1000, 160);
		test_random(16'd1, 160);
		test_random(16'd65535, 160);
		test_random(16'd7, 160);
		test_random(16'($urandom_range(2, 65534)), 160);

		drain();
		repeat (SETTLE) @(posedge clk);
		$display("sent %0d words, checked %0d results over six tick periods incl. zero",
			words_sent, words_checked);
		$display("slot firings seen %0d, rejected schedules %0d, mismatches %0d",
			fires_seen, rejects_seen, errors);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
